/* sv/sha512_stream_hash_core_defines.svh */
// assertion macros for the sha-512 stream core
`ifndef SHA512_STREAM_HASH_CORE_DEFINES_SVH
`define SHA512_STREAM_HASH_CORE_DEFINES_SVH

// plain property, sampled on clk, off during reset
`define S512_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in this cycle implies expectation in the next
`define S512_ASSERT_NEXT(name, cond, expect_next, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expect_next)) \
		else $error(msg);

`endif

/* sv/s512_pkg.sv */
package s512_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int BLOCK_WORDS = BLOCK_BYTES / 8;
	localparam int HASH_WORDS = 8;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_beat_t;

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] ssig0(input logic [63:0] x);
		return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic logic [63:0] ssig1(input logic [63:0] x);
		return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

	function automatic logic [63:0] init_hash(input logic [2:0] i);
		logic [63:0] r;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			3'd7: r = 64'h5be0cd19137e2179;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] r;
		case (t)
			7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
			7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
			7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
			7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
			7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
			7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
			7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
			7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
			7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
			7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
			7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
			7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
			7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
			7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
			7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
			7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
			7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
			7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
			7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
			7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
			7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
			7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
			7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
			7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
			7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
			7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
			7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
			7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
			7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
			7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
			7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
			7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
			7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
			7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
			7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
			7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
			7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
			7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
			7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
			7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* sv/s512_ram.sv */
module s512_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/sha512_stream_hash_core.sv */
// sha-512 stream core: absorb beats are taken while idle; a full 128-byte block then
// holds input off while it is compressed (hash loads, 80 rounds, hash write-backs).
// finish: the rest of the block is padded and compressed, plus a second padding
// block when the length does not fit, then 8 digest beats, each beat read only
// once the output register has drained. compression runs one round per cycle
// arst_n low: initial hash values, empty buffer, zero length, no output beat.
`include "sha512_stream_hash_core_defines.svh"

module sha512_stream_hash_core import s512_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	// controller states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FINAL = 3'd4;
	localparam logic [2:0] ST_ORD   = 3'd5;
	localparam logic [2:0] ST_OCAP  = 3'd6;

	logic [2:0]  state_q;
	logic [6:0]  ctr_q;        // load/round/write-back step
	logic [6:0]  cnt_q;        // bytes waiting in the block store
	logic [60:0] lo_q;         // compressed byte count, low part
	logic [63:0] hi_q;         // carries out of the low part
	logic        fin_q;        // compression belongs to a finish
	logic        pass2_q;      // second padding block
	logic [3:0]  wp_q;         // pad write pointer
	logic [7:0]  hvalid_q;     // hash word written since reset/finish
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic [63:0]       acc_q;  // partial big-endian word being assembled
	logic [7:0][63:0]  v_q;    // working variables, a at index 0
	logic [15:0][63:0] w_q;    // schedule window, current w at index 15
	logic [2:0]        hraddr_s1;

	// block store ram: 16 words of 64 bits
	logic        b_we;
	logic [3:0]  b_waddr;
	logic [63:0] b_wdata;
	logic [3:0]  b_raddr;
	logic [63:0] b_rdata;

	// hash word ram: 8 words of 64 bits, initial values through hvalid_q
	logic        h_we;
	logic [2:0]  h_waddr;
	logic [63:0] h_wdata;
	logic [2:0]  h_raddr;
	logic [63:0] h_rdata;
	logic [63:0] hrd_eff;

	logic        in_acc;
	logic [3:0]  pword;
	logic [2:0]  pbyte;
	logic        lenblk;
	logic [5:0]  psh;
	logic [71:0] part72;
	logic [63:0] pad_word;
	logic [61:0] sum62;
	logic [63:0] t1, t2, wnext;

	s512_ram #(.WIDTH(64), .DEPTH(BLOCK_WORDS)) u_block (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	s512_ram #(.WIDTH(64), .DEPTH(HASH_WORDS)) u_hash (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// unwritten hash entries read as the initial value
	assign hrd_eff = hvalid_q[hraddr_s1] ? h_rdata : init_hash(hraddr_s1);

	// padding: word with the tail bytes, 0x80 marker, zeros and the length
	assign pword  = cnt_q[6:3];
	assign pbyte  = cnt_q[2:0];
	assign lenblk = pass2_q || (pword < LEN_HI_WORD);
	assign psh    = {3'(3'd7 - pbyte), 3'b000};
	assign part72 = {acc_q, 8'h80} << psh;

	always_comb begin
		pad_word = '0;
		if (!pass2_q && wp_q == pword) begin
			pad_word = part72[63:0];
		end else if (lenblk && wp_q == LEN_HI_WORD) begin
			pad_word = hi_q;
		end else if (lenblk && wp_q == LEN_LO_WORD) begin
			pad_word = {lo_q, 3'b000};
		end
	end

	// length update: 128 per full block, buffered bytes on finish
	assign sum62 = {1'b0, lo_q} + (in_data.kind ? 62'(cnt_q) : 62'(BLOCK_BYTES));

	// one round and next schedule word
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(ctr_q) + w_q[15];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign wnext = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];

	// memory port steering
	always_comb begin
		b_we    = 1'b0;
		b_waddr = pword;
		b_wdata = {acc_q[55:0], in_data.data_byte};
		b_raddr = '0;
		h_we    = 1'b0;
		h_waddr = hraddr_s1;
		h_wdata = hrd_eff + v_q[0];
		h_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				b_we = in_acc && !in_data.kind && (pbyte == 3'd7);
			end
			ST_PAD: begin
				b_we    = 1'b1;
				b_waddr = wp_q;
				b_wdata = pad_word;
			end
			ST_LOAD: begin
				h_raddr = ctr_q[2:0];
				b_raddr = (ctr_q == 7'd8) ? 4'd1 : 4'd0;
			end
			ST_ROUND: begin
				b_raddr = ctr_q[3:0] + 4'd2;
			end
			ST_FINAL: begin
				h_raddr = ctr_q[2:0];
				h_we    = (ctr_q != 7'd0);
			end
			ST_ORD: begin
				h_raddr = oidx_q;
			end
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= '0;
			cnt_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			fin_q       <= 1'b0;
			pass2_q     <= 1'b0;
			wp_q        <= '0;
			hvalid_q    <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!in_data.kind) begin
							cnt_q <= cnt_q + 7'd1;
							if (cnt_q == 7'(BLOCK_BYTES - 1)) begin
								lo_q <= sum62[60:0];
								if (sum62[61]) begin
									hi_q <= hi_q + 64'd1;
								end
								fin_q   <= 1'b0;
								ctr_q   <= '0;
								state_q <= ST_LOAD;
							end
						end else begin
							lo_q <= sum62[60:0];
							if (sum62[61]) begin
								hi_q <= hi_q + 64'd1;
							end
							fin_q   <= 1'b1;
							pass2_q <= 1'b0;
							wp_q    <= pword;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					wp_q <= wp_q + 4'd1;
					if (wp_q == LEN_LO_WORD) begin
						ctr_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (ctr_q == 7'd8) begin
						ctr_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						ctr_q <= ctr_q + 7'd1;
					end
				end
				ST_ROUND: begin
					if (ctr_q == LAST_ROUND) begin
						ctr_q   <= '0;
						state_q <= ST_FINAL;
					end else begin
						ctr_q <= ctr_q + 7'd1;
					end
				end
				ST_FINAL: begin
					if (ctr_q != 7'd0) begin
						hvalid_q[hraddr_s1] <= 1'b1;
					end
					if (ctr_q == 7'd8) begin
						ctr_q <= '0;
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (lenblk) begin
							oidx_q  <= '0;
							state_q <= ST_ORD;
						end else begin
							pass2_q <= 1'b1;
							wp_q    <= '0;
							state_q <= ST_PAD;
						end
					end else begin
						ctr_q <= ctr_q + 7'd1;
					end
				end
				ST_ORD: begin
					// read only once the output register has drained
					if (!out_valid_q) begin
						state_q <= ST_OCAP;
					end
				end
				ST_OCAP: begin
					out_valid_q <= 1'b1;
					if (oidx_q == 3'd7) begin
						hvalid_q <= '0;
						cnt_q    <= '0;
						lo_q     <= '0;
						hi_q     <= '0;
						fin_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						oidx_q  <= oidx_q + 3'd1;
						state_q <= ST_ORD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		hraddr_s1 <= h_raddr;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !in_data.kind) begin
					acc_q <= {acc_q[55:0], in_data.data_byte};
				end
			end
			ST_LOAD: begin
				if (ctr_q != 7'd0) begin
					v_q <= {hrd_eff, v_q[7:1]};
				end
				if (ctr_q == 7'd8) begin
					w_q <= {b_rdata, w_q[15:1]};
				end
			end
			ST_ROUND: begin
				v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
				w_q <= {(ctr_q < 7'd15) ? b_rdata : wnext, w_q[15:1]};
			end
			ST_FINAL: begin
				if (ctr_q != 7'd0) begin
					v_q <= {v_q[0], v_q[7:1]};
				end
			end
			ST_OCAP: begin
				out_q.digest_word <= hrd_eff;
				out_q.word_index  <= oidx_q;
				out_q.last_word   <= (oidx_q == 3'd7);
			end
			default: begin
			end
		endcase
	end

	`S512_ASSERT(a_round_bound, (state_q == ST_ROUND) |-> (ctr_q <= LAST_ROUND), "round step past last round")
	`S512_ASSERT(a_last_index, (out_valid && out_data.last_word) |-> (out_data.word_index == 3'd7), "last flag off the final word")
	`S512_ASSERT_NEXT(a_digest_continues, out_valid && out_ready && !out_data.last_word, state_q != ST_IDLE, "digest stopped before last word")

endmodule

/* test/sha512_stream_hash_core_test.sv */
module sha512_stream_hash_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import s512_pkg::*;

	// beat kinds on the input channel
	localparam logic KIND_ABSORB = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// run limit in clock cycles, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT = 600000;
	// long receiver hold-off, in cycles, used to back the core up
	localparam int unsigned HOLD_CYCLES = 700;

	// sha-512 round constants
	localparam logic [63:0] SHA_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// initial chaining value
	localparam logic [63:0] SHA_IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	sha512_stream_hash_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// predictor state: chaining value, partial block, byte counters
	logic [63:0] chain [8];
	logic [7:0]  msg_block [128];
	int unsigned block_fill;
	logic [60:0] bytes_done_lo;
	logic [63:0] bytes_done_hi;

	// digest beats still owed by the core, oldest first
	out_beat_t   digest_queue [$];

	int unsigned cycle_count;
	int unsigned error_count;
	int unsigned beats_sent;
	int unsigned messages_done;
	int unsigned words_checked;
	bit          gaps_on;        // random idling on both sides
	bit          hold_request;   // ask the receiver for one long hold-off

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// one 80-round compression of msg_block into chain
	function automatic void compress_block();
		logic [63:0] w [80];
		logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) begin
			w[i] = {msg_block[8*i], msg_block[8*i+1], msg_block[8*i+2], msg_block[8*i+3],
				msg_block[8*i+4], msg_block[8*i+5], msg_block[8*i+6], msg_block[8*i+7]};
		end
		for (int i = 16; i < 80; i++) begin
			s0 = rotr64(w[i-15], 1) ^ rotr64(w[i-15], 8) ^ (w[i-15] >> 7);
			s1 = rotr64(w[i-2], 19) ^ rotr64(w[i-2], 61) ^ (w[i-2] >> 6);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int i = 0; i < 80; i++) begin
			t1 = h + (rotr64(e, 14) ^ rotr64(e, 18) ^ rotr64(e, 41)) + ((e & f) ^ (~e & g))
				+ SHA_K[i] + w[i];
			t2 = (rotr64(a, 28) ^ rotr64(a, 34) ^ rotr64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	// 61-bit low count, overflow carried into the high word
	function automatic void count_bytes(input int unsigned n);
		logic [63:0] sum;
		sum = {3'b000, bytes_done_lo} + 64'(n);
		bytes_done_hi += sum >> 61;
		bytes_done_lo = sum[60:0];
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++) begin
			chain[i] = SHA_IV[i];
		end
		block_fill = 0;
		bytes_done_lo = '0;
		bytes_done_hi = '0;
	endfunction

	// apply one accepted input beat to the predictor
	function automatic void predict_digest(input in_beat_t beat);
		logic [63:0] len_hi, len_lo;
		out_beat_t   word;
		if (beat.kind == KIND_ABSORB) begin
			msg_block[block_fill] = beat.data_byte;
			block_fill++;
			if (block_fill == 128) begin
				compress_block();
				count_bytes(128);
				block_fill = 0;
			end
			return;
		end
		count_bytes(block_fill);
		len_hi = bytes_done_hi;
		len_lo = {bytes_done_lo, 3'b000};
		// end marker, then zero fill to the end of the block
		msg_block[block_fill] = 8'h80;
		for (int i = block_fill + 1; i < 128; i++) begin
			msg_block[i] = 8'h00;
		end
		// no room for the length: spill into an extra all-zero block
		if (block_fill + 1 > 112) begin
			compress_block();
			for (int i = 0; i < 128; i++) begin
				msg_block[i] = 8'h00;
			end
		end
		for (int j = 0; j < 8; j++) begin
			msg_block[112 + j] = len_hi[63 - 8*j -: 8];
			msg_block[120 + j] = len_lo[63 - 8*j -: 8];
		end
		compress_block();
		for (int i = 0; i < 8; i++) begin
			word.digest_word = chain[i];
			word.word_index = 3'(i);
			word.last_word = (i == 7);
			digest_queue.push_back(word);
		end
		messages_done++;
		restart_message();
	endfunction

	function automatic int unsigned draw_gap();
		if (!gaps_on || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// send one beat; entered and left at a falling edge
	task automatic send_beat(input logic kind, input logic [7:0] data_byte);
		in_beat_t    beat;
		int unsigned gap;
		beat.kind = kind;
		beat.data_byte = data_byte;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_digest(beat);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned length);
		for (int unsigned i = 0; i < length; i++) begin
			send_beat(KIND_ABSORB, 8'($urandom_range(0, 255)));
		end
		send_beat(KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// known short messages, byte extremes, finish with junk data byte
	task automatic test_short_messages();
		gaps_on = 1'b0;
		send_beat(KIND_FINISH, 8'hff);          // empty message
		send_beat(KIND_ABSORB, 8'h61);
		send_beat(KIND_ABSORB, 8'h62);
		send_beat(KIND_ABSORB, 8'h63);
		send_beat(KIND_FINISH, 8'h00);          // "abc"
		gaps_on = 1'b1;
		send_beat(KIND_ABSORB, 8'h00);
		send_beat(KIND_ABSORB, 8'hff);
		send_beat(KIND_ABSORB, 8'h55);
		send_beat(KIND_ABSORB, 8'haa);
		send_beat(KIND_FINISH, 8'h80);
		send_beat(KIND_FINISH, 8'h01);          // back-to-back empty message
	endtask

	// length field forces an extra padding block
	task automatic test_two_block_padding();
		gaps_on = 1'b1;
		send_message(112);
	endtask

	// a full block absorbed mid-message, with the receiver holding off
	task automatic test_full_block_under_stall();
		gaps_on = 1'b0;
		hold_request = 1'b1;
		send_message(3);
		send_message(130);
		gaps_on = 1'b1;
	endtask

	// random short messages, most of the random beats
	task automatic test_random_messages();
		for (int m = 0; m < 8; m++) begin
			gaps_on = (m % 3 != 2);
			send_message($urandom_range(0, 9));
		end
	endtask

	// receiver: random ready gaps, plus the one long hold-off on request
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (hold_request) begin
				gap = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!out_valid);
		end
	end

	// compare each accepted digest beat with the oldest expected one
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (digest_queue.size() == 0) begin
				$error("digest beat with nothing expected: word %h index %0d",
					out_data.digest_word, out_data.word_index);
				error_count++;
			end else begin
				want = digest_queue.pop_front();
				words_checked++;
				if (out_data.digest_word !== want.digest_word) begin
					$error("digest_word expected %h actual %h", want.digest_word,
						out_data.digest_word);
					error_count++;
				end
				if (out_data.word_index !== want.word_index) begin
					$error("word_index expected %0d actual %0d", want.word_index,
						out_data.word_index);
					error_count++;
				end
				if (out_data.last_word !== want.last_word) begin
					$error("last_word expected %0d actual %0d", want.last_word,
						out_data.last_word);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digest beats outstanding", cycle_count,
				digest_queue.size());
			$display("sha512_stream_hash_core test failed");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		error_count = 0;
		beats_sent = 0;
		messages_done = 0;
		words_checked = 0;
		gaps_on = 1'b0;
		hold_request = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		for (int i = 0; i < 128; i++) begin
			msg_block[i] = 8'h00;
		end
		restart_message();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_short_messages();
		test_two_block_padding();
		test_full_block_under_stall();
		test_random_messages();
		in_valid <= 1'b0;

		// drain, then let the core settle
		while (digest_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);

		$display("%0d input beats, %0d messages, %0d digest words checked", beats_sent,
			messages_done, words_checked);
		$display("covered empty and short messages, a two-block pad and a long output stall");
		if (error_count == 0) begin
			$display("sha512_stream_hash_core test passed");
		end else begin
			$display("sha512_stream_hash_core test failed");
		end
		$finish;
	end

endmodule
